// ===== sv/jo_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint orientation package
// Shared widths, constants and helper functions for the joint orientation
// and arm extension block.
// ----------------------------------------------------------------------------
package jo_pkg;

  localparam int NUM_JOINTS_DEF   = 10;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ID_W   = 4;
  localparam int POS_W  = 16;
  localparam int QUAT_W = 16;
  localparam int CONF_W = 9;

  // CORDIC operand and angle widths
  localparam int CIN_W  = 34;
  localparam int CORD_W = 37;
  localparam int ZW     = 27;
  localparam int ATAN_LEN = 24;

  // Shared multiplier and accumulators
  localparam int MUL_W = 30;
  localparam int ACC_W = 36;

  // Square root and divider widths
  localparam int SQ_W   = 58;
  localparam int SQ_RW  = SQ_W / 2;
  localparam int DIST_W = 26;
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 27;

  localparam logic [ID_W-1:0]   LEFT_HAND_ID    = 4'd0;
  localparam logic [ID_W-1:0]   RIGHT_HAND_ID   = 4'd3;
  localparam logic [CONF_W-1:0] THRESHOLD_RESET = 9'd128;

  localparam logic signed [CIN_W-1:0] Q28_ONE = 34'sd268435456;
  localparam logic signed [ZW-1:0]    DEG180  = 27'sd11796480;
  localparam logic signed [17:0] ROT_XZ_LIM = 18'sd11520;
  localparam logic signed [17:0] ROT_Y_LIM  = 18'sd5760;
  localparam logic [6:0] EXT_MAX = 7'd100;

  // Arctangent of 2^-i in degrees, Q.16, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58666;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rounds a Q.16 angle to Q.6 and saturates it to +-lim.
  function automatic logic signed [14:0] to_q6(input logic signed [ZW-1:0] z,
                                               input logic signed [17:0] lim);
    logic signed [27:0] t;
    logic signed [17:0] r;
    t = 28'(z) + 28'sd512;
    r = t[27:10];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r[14:0];
  endfunction

endpackage

// ===== sv/jo_if.sv =====
// ----------------------------------------------------------------------------
// Joint orientation channels
// Valid/ready channels for joint samples and for their results.
// ----------------------------------------------------------------------------
interface jo_sample_if;
  logic        valid;
  logic        ready;
  logic [3:0]  joint_id;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic [8:0]  confidence;

  modport source (output valid, joint_id, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                  quat_z, confidence, input ready);
  modport sink (input valid, joint_id, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                quat_z, confidence, output ready);
endinterface

interface jo_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_joint_id;
  logic signed [14:0] rot_x;
  logic signed [13:0] rot_y;
  logic signed [14:0] rot_z;
  logic        active;
  logic [6:0]  extension_percent;
  logic        extension_valid;

  modport source (output valid, out_joint_id, rot_x, rot_y, rot_z, active,
                  extension_percent, extension_valid, input ready);
  modport sink (input valid, out_joint_id, rot_x, rot_y, rot_z, active,
                extension_percent, extension_valid, output ready);
endinterface

// ===== sv/jo_isqrt.sv =====
// ----------------------------------------------------------------------------
// Serial square root
// Floor square root, two radicand bits per cycle through a shift register.
// ----------------------------------------------------------------------------
module jo_isqrt #(
  parameter int W = jo_pkg::SQ_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   val,
  output logic           done,
  output logic [W/2-1:0] root
);

  localparam int R    = W / 2;
  localparam int CNTW = $clog2(R + 1);

  logic [W-1:0]    v;
  logic [R+1:0]    rem;
  logic [R-1:0]    root_r;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done_r;

  logic [R+3:0] rem_t;
  logic [R+3:0] trial;
  logic [R+3:0] rem_d;
  logic         ge;

  assign rem_t = {rem, v[W-1:W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign rem_d = rem_t - trial;
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v      <= val;
        rem    <= '0;
        root_r <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        rem    <= ge ? rem_d[R+1:0] : rem_t[R+1:0];
        root_r <= {root_r[R-2:0], ge};
        v      <= {v[W-3:0], 2'b00};
        cnt    <= cnt + 1'b1;
        if (cnt == CNTW'(R - 1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== sv/jo_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jo_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [jo_pkg::DIV_NW-1:0] num,
  input  logic [jo_pkg::DIV_DW-1:0] den,
  output logic                      done,
  output logic [jo_pkg::DIV_NW-1:0] quot
);

  localparam int NW   = jo_pkg::DIV_NW;
  localparam int DW   = jo_pkg::DIV_DW;
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q;
  logic [DW-1:0]   d;
  logic [DW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done_r;

  logic [DW:0] rem_t;
  logic [DW:0] rem_d;
  logic        ge;

  assign rem_t = {rem, q[NW-1]};
  assign rem_d = rem_t - {1'b0, d};
  assign ge    = rem_t >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? rem_d[DW-1:0] : rem_t[DW-1:0];
        q   <= {q[NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q;

endmodule

// ===== sv/jo_cordic.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Iterative atan2 in degrees, Q.16, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module jo_cordic #(
  parameter int STEPS = jo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [jo_pkg::CIN_W-1:0] y_in,
  input  logic signed [jo_pkg::CIN_W-1:0] x_in,
  output logic                            done,
  output logic signed [jo_pkg::ZW-1:0]    z_out
);

  localparam int CW = jo_pkg::CORD_W;
  localparam logic [4:0] LAST = 5'(STEPS - 1);

  logic signed [CW-1:0]        x;
  logic signed [CW-1:0]        y;
  logic signed [jo_pkg::ZW-1:0] z;
  logic [4:0]                  it;
  logic                        busy;
  logic                        done_r;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [jo_pkg::ZW-1:0] da;

  assign dx = y >>> it;
  assign dy = x >>> it;
  assign da = jo_pkg::atan_deg(it);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      it     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        it <= '0;
        if (x_in == '0 && y_in == '0) begin
          z      <= '0;
          done_r <= 1'b1;
        end else begin
          busy <= 1'b1;
          // A vector in the left half-plane is turned by a half revolution first.
          if (x_in < 0) begin
            x <= -CW'(x_in);
            y <= -CW'(y_in);
            z <= (y_in >= 0) ? jo_pkg::DEG180 : -jo_pkg::DEG180;
          end else begin
            x <= CW'(x_in);
            y <= CW'(y_in);
            z <= '0;
          end
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + da;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - da;
        end
        it <= it + 1'b1;
        if (it == LAST) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign z_out = z;

endmodule

// ===== sv/joint_orientation_and_arm_extension.sv =====
// ----------------------------------------------------------------------------
// Joint orientation and arm extension
// Euler angles from a joint quaternion, activity flag and hand extension.
// ----------------------------------------------------------------------------
// The block takes one joint sample at a time and returns one result for it.
// The time from acceptance to result is set by the shared CORDIC unit,
// which runs three passes of CORDIC_STEPS iterations, by the square root
// unit, which retires two radicand bits per cycle (once for the pitch
// angle and three more times for a hand), and by the bit-serial divider.
// A new sample is taken as soon as the previous one has left the datapath;
// its result may still wait in the output register.
module joint_orientation_and_arm_extension #(
  parameter int NUM_JOINTS   = jo_pkg::NUM_JOINTS_DEF,
  parameter int CORDIC_STEPS = jo_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  jo_sample_if.sink   sample,
  jo_result_if.source result
);

  localparam int IW = $clog2(NUM_JOINTS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PROD  = 4'd1;
  localparam logic [3:0] ST_ROTX  = 4'd2;
  localparam logic [3:0] ST_ROTZ  = 4'd3;
  localparam logic [3:0] ST_ASQ   = 4'd4;
  localparam logic [3:0] ST_ASQRT = 4'd5;
  localparam logic [3:0] ST_ROTY  = 4'd6;
  localparam logic [3:0] ST_RDPOS = 4'd7;
  localparam logic [3:0] ST_DSQ   = 4'd8;
  localparam logic [3:0] ST_DSQRT = 4'd9;
  localparam logic [3:0] ST_PCT   = 4'd10;
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  localparam int MW = jo_pkg::MUL_W;
  localparam int AW = jo_pkg::ACC_W;

  logic [3:0] state;
  logic [3:0] step;
  logic [1:0] pair;

  logic [8:0]  active_threshold;
  logic [47:0] pos_store [NUM_JOINTS];

  // Latched sample
  logic [3:0]         id_r;
  logic signed [15:0] px, py, pz;
  logic signed [15:0] qw, qx, qy, qz;
  logic [8:0]         conf_r;
  logic               hand_ok;

  // Products and intermediate values
  logic signed [2*MW-1:0] mul_p;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [AW-1:0]   acc_nx, acc_sy, acc_nz, acc_sxz, acc_ar;
  logic signed [MW-1:0]   a_r;
  logic [jo_pkg::SQ_RW-1:0] c_r;
  logic [47:0]  e_pos, s_pos;
  logic [33:0]  dsum;
  logic [jo_pkg::DIST_W-1:0] d_he, d_hs, d_es;

  logic signed [14:0] rx_r, rz_r;
  logic signed [13:0] ry_r;
  logic [6:0]         ext_r;

  logic accept;
  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);

  // Angle operands
  logic signed [33:0] nx2, dx2, nz2, dz2;
  logic signed [34:0] ar2;
  logic signed [MW-1:0] a_clamp;

  assign nx2 = {acc_nx[32:0], 1'b0};
  assign dx2 = jo_pkg::Q28_ONE - {acc_sy[32:0], 1'b0};
  assign nz2 = {acc_nz[32:0], 1'b0};
  assign dz2 = jo_pkg::Q28_ONE - {acc_sxz[32:0], 1'b0};
  assign ar2 = {acc_ar[33:0], 1'b0};

  always_comb begin
    if (ar2 > 35'sd268435456) begin
      a_clamp = 30'sd268435456;
    end else if (ar2 < -35'sd268435456) begin
      a_clamp = -30'sd268435456;
    end else begin
      a_clamp = ar2[MW-1:0];
    end
  end

  // Distance operands
  logic [47:0] pa, pb;
  logic signed [15:0] ca, cb;
  logic signed [16:0] diff;
  logic [IW-1:0] rd_idx;
  logic [3:0] elb_id, sh_id;

  assign elb_id = id_r + 4'd1;
  assign sh_id  = id_r + 4'd2;
  assign rd_idx = (step == 4'd0) ? elb_id[IW-1:0] : sh_id[IW-1:0];
  assign pa     = (pair == 2'd2) ? e_pos : {pz, py, px};
  assign pb     = (pair == 2'd0) ? e_pos : s_pos;

  always_comb begin
    case (step)
      4'd0: begin ca = pa[15:0];  cb = pb[15:0];  end
      4'd1: begin ca = pa[31:16]; cb = pb[31:16]; end
      4'd2: begin ca = pa[47:32]; cb = pb[47:32]; end
      default: begin ca = '0; cb = '0; end
    endcase
  end

  assign diff = 17'(ca) - 17'(cb);

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PROD: begin
        case (step)
          4'd0: begin mul_a = MW'(qy); mul_b = MW'(qw); end
          4'd1: begin mul_a = MW'(qx); mul_b = MW'(qz); end
          4'd2: begin mul_a = MW'(qy); mul_b = MW'(qy); end
          4'd3: begin mul_a = MW'(qz); mul_b = MW'(qz); end
          4'd4: begin mul_a = MW'(qx); mul_b = MW'(qw); end
          4'd5: begin mul_a = MW'(qy); mul_b = MW'(qz); end
          4'd6: begin mul_a = MW'(qx); mul_b = MW'(qx); end
          4'd7: begin mul_a = MW'(qx); mul_b = MW'(qy); end
          4'd8: begin mul_a = MW'(qz); mul_b = MW'(qw); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_ASQ: begin
        mul_a = a_r;
        mul_b = a_r;
      end
      ST_DSQ: begin
        mul_a = MW'(diff);
        mul_b = MW'(diff);
      end
      ST_PCT: begin
        mul_a = {4'b0, d_hs};
        mul_b = 30'sd100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Shared CORDIC
  logic cordic_start, cordic_done;
  logic signed [jo_pkg::CIN_W-1:0] cordic_y, cordic_x;
  logic signed [jo_pkg::ZW-1:0]    cordic_z;
  logic signed [14:0] q6_xz, q6_y;

  assign cordic_start = (state == ST_ROTX || state == ST_ROTZ || state == ST_ROTY) &&
                        step == 4'd0;

  always_comb begin
    case (state)
      ST_ROTX: begin cordic_y = nx2; cordic_x = dx2; end
      ST_ROTZ: begin cordic_y = nz2; cordic_x = dz2; end
      default: begin cordic_y = jo_pkg::CIN_W'(a_r); cordic_x = {5'b0, c_r}; end
    endcase
  end

  jo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .y_in  (cordic_y),
    .x_in  (cordic_x),
    .done  (cordic_done),
    .z_out (cordic_z)
  );

  assign q6_xz = jo_pkg::to_q6(cordic_z, jo_pkg::ROT_XZ_LIM);
  assign q6_y  = jo_pkg::to_q6(cordic_z, jo_pkg::ROT_Y_LIM);

  // Shared square root
  logic sqrt_start, sqrt_done;
  logic [jo_pkg::SQ_W-1:0]  sqrt_val;
  logic [jo_pkg::SQ_RW-1:0] sqrt_root;
  logic [56:0] asq_rem;

  assign asq_rem    = {1'b1, 56'b0} - mul_p[56:0];
  assign sqrt_start = (state == ST_ASQ && step == 4'd1) ||
                      (state == ST_DSQRT && step == 4'd0);
  assign sqrt_val   = (state == ST_ASQ) ? {1'b0, asq_rem} : {8'b0, dsum, 16'b0};

  jo_isqrt #(.W(jo_pkg::SQ_W)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .val   (sqrt_val),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Divider
  logic div_start, div_done;
  logic [jo_pkg::DIV_DW-1:0] den_sum;
  logic [jo_pkg::DIV_NW-1:0] div_q;

  assign den_sum   = {1'b0, d_es} + {1'b0, d_he};
  assign div_start = (state == ST_PCT) && step == 4'd1 && den_sum != '0;

  jo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_p[jo_pkg::DIV_NW-1:0]),
    .den   (den_sum),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step             <= '0;
      pair             <= '0;
      active_threshold <= jo_pkg::THRESHOLD_RESET;
      result.valid     <= 1'b0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        pos_store[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        active_threshold <= cfg_wdata;
      end
      if (accept && 32'(sample.joint_id) < NUM_JOINTS) begin
        pos_store[sample.joint_id[IW-1:0]] <= {sample.pos_z, sample.pos_y, sample.pos_x};
      end
      // When a result leaves while the next one is ready, the done state reloads it.
      if (result.valid && result.ready && state != ST_DONE) begin
        result.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            id_r    <= sample.joint_id;
            px      <= sample.pos_x;
            py      <= sample.pos_y;
            pz      <= sample.pos_z;
            qw      <= sample.quat_w;
            qx      <= sample.quat_x;
            qy      <= sample.quat_y;
            qz      <= sample.quat_z;
            conf_r  <= sample.confidence;
            hand_ok <= (sample.joint_id == jo_pkg::LEFT_HAND_ID ||
                        sample.joint_id == jo_pkg::RIGHT_HAND_ID) &&
                       32'(sample.joint_id) + 2 < NUM_JOINTS;
            state   <= ST_PROD;
            step    <= '0;
          end
        end

        // Each product is registered and taken up in the cycle after its operands were issued.
        ST_PROD: begin
          case (step)
            4'd1: acc_nx  <= AW'(mul_p);
            4'd2: acc_nx  <= acc_nx - AW'(mul_p);
            4'd3: acc_sy  <= AW'(mul_p);
            4'd4: begin
              acc_sy  <= acc_sy + AW'(mul_p);
              acc_sxz <= AW'(mul_p);
            end
            4'd5: acc_nz  <= AW'(mul_p);
            4'd6: acc_nz  <= acc_nz - AW'(mul_p);
            4'd7: acc_sxz <= acc_sxz + AW'(mul_p);
            4'd8: acc_ar  <= AW'(mul_p);
            4'd9: acc_ar  <= acc_ar + AW'(mul_p);
            default: ;
          endcase
          if (step == 4'd9) begin
            state <= ST_ROTX;
            step  <= '0;
          end else begin
            step <= step + 4'd1;
          end
        end

        ST_ROTX: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (cordic_done) begin
            rx_r  <= q6_xz;
            a_r   <= a_clamp;
            state <= ST_ROTZ;
            step  <= '0;
          end
        end

        ST_ROTZ: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (cordic_done) begin
            rz_r  <= q6_xz;
            state <= ST_ASQ;
            step  <= '0;
          end
        end

        ST_ASQ: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else begin
            state <= ST_ASQRT;
            step  <= '0;
          end
        end

        ST_ASQRT: begin
          if (sqrt_done) begin
            c_r   <= sqrt_root;
            state <= ST_ROTY;
            step  <= '0;
          end
        end

        ST_ROTY: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (cordic_done) begin
            ry_r <= q6_y[13:0];
            step <= '0;
            if (hand_ok) begin
              state <= ST_RDPOS;
            end else begin
              ext_r <= '0;
              state <= ST_DONE;
            end
          end
        end

        ST_RDPOS: begin
          if (step == 4'd0) begin
            e_pos <= pos_store[rd_idx];
            step  <= 4'd1;
          end else begin
            s_pos <= pos_store[rd_idx];
            pair  <= '0;
            state <= ST_DSQ;
            step  <= '0;
          end
        end

        ST_DSQ: begin
          case (step)
            4'd1: dsum <= 34'(mul_p);
            4'd2: dsum <= dsum + 34'(mul_p);
            4'd3: dsum <= dsum + 34'(mul_p);
            default: ;
          endcase
          if (step == 4'd3) begin
            state <= ST_DSQRT;
            step  <= '0;
          end else begin
            step <= step + 4'd1;
          end
        end

        ST_DSQRT: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (sqrt_done) begin
            case (pair)
              2'd0: d_he <= sqrt_root[jo_pkg::DIST_W-1:0];
              2'd1: d_hs <= sqrt_root[jo_pkg::DIST_W-1:0];
              default: d_es <= sqrt_root[jo_pkg::DIST_W-1:0];
            endcase
            step <= '0;
            if (pair == 2'd2) begin
              state <= ST_PCT;
            end else begin
              pair  <= pair + 2'd1;
              state <= ST_DSQ;
            end
          end
        end

        ST_PCT: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (den_sum == '0) begin
            ext_r <= '0;
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            ext_r <= (div_q > 32'(jo_pkg::EXT_MAX)) ? jo_pkg::EXT_MAX : div_q[6:0];
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid             <= 1'b1;
            result.out_joint_id      <= id_r;
            result.rot_x             <= rx_r;
            result.rot_y             <= ry_r;
            result.rot_z             <= rz_r;
            result.active            <= conf_r > active_threshold;
            result.extension_percent <= ext_r;
            result.extension_valid   <= hand_ok;
            state                    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_PROD)
    else $error("accepted sample did not start the product sequence");

  a_ext_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.extension_valid |-> result.extension_percent == 7'd0)
    else $error("extension given for a joint that is not a hand");

  a_ext_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.extension_percent <= jo_pkg::EXT_MAX)
    else $error("extension above full reach");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.rot_y <= 14'sd5760 && result.rot_y >= -14'sd5760))
    else $error("pitch angle out of range");

endmodule
